[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tks_pkg.sv]
// ----------------------------------------------------------------------------
// Top-k select package
// Register indexes and shared types of the thresholded top-k select block.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

   // Width of the configuration register index.
   localparam int CSR_INDEX_BITS = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCORE_FLOOR = 2'd2;

   // Fill status of the row queue between the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[hdl/tks_queue.sv]
// ----------------------------------------------------------------------------
// Row queue
// Two-entry queue that carries finished row snapshots from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_queue #(
   parameter int DATA_W = 104
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [DATA_W-1:0]         push_data,
   input  wire logic                      pop,
   output      logic [DATA_W-1:0]         head_data,
   output      tks_pkg::queue_status_type status
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only occupied entries are read.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

`default_nettype wire

[hdl/tks_front.sv]
// ----------------------------------------------------------------------------
// Top-k select front part
// Counts columns, filters scores against the floor and keeps the sorted list.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_front #(
   parameter int MAX_KEEP   = 8,
   parameter int MAX_ROW    = 4096,
   parameter int SCORE_BITS = 16,
   localparam int COL_W     = $clog2(MAX_ROW),
   localparam int RLW       = COL_W + 1,
   localparam int KCW       = $clog2(MAX_KEEP) + 1,
   localparam int DATA_W    = MAX_KEEP * COL_W + 2 * KCW
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic signed [SCORE_BITS-1:0] req_score,
   input  wire logic [RLW-1:0]               row_length,
   input  wire logic [KCW-1:0]               keep_count,
   input  wire logic signed [SCORE_BITS-1:0] score_floor,
   input  wire tks_pkg::queue_status_type    queue_status,
   output      logic                         push,
   output      logic [DATA_W-1:0]            push_data
);

   logic signed [SCORE_BITS-1:0] score_ff [MAX_KEEP];
   logic signed [SCORE_BITS-1:0] score_in [MAX_KEEP];
   logic [COL_W-1:0]             column_ff [MAX_KEEP];
   logic [COL_W-1:0]             column_in [MAX_KEEP];
   logic [KCW-1:0]               total_ff;
   logic [KCW-1:0]               total_in;
   logic [COL_W-1:0]             counter_ff;
   logic [COL_W-1:0]             counter_in;

   logic [RLW-1:0]               row_eff;
   logic [KCW-1:0]               keep_eff;
   logic [KCW-1:0]               total_cut;
   logic [KCW-1:0]               total_new;
   logic [KCW-1:0]               position;
   logic [MAX_KEEP-1:0]          not_below;
   logic                         above_floor;
   logic                         insert;
   logic                         row_end;
   logic                         accept;

   // Out-of-range settings are clamped to the legal span.
   always_comb begin
      if (row_length == '0) begin
         row_eff = RLW'(1);
      end else if (row_length > RLW'(MAX_ROW)) begin
         row_eff = RLW'(MAX_ROW);
      end else begin
         row_eff = row_length;
      end
      if (keep_count == '0) begin
         keep_eff = KCW'(1);
      end else if (keep_count > KCW'(MAX_KEEP)) begin
         keep_eff = KCW'(MAX_KEEP);
      end else begin
         keep_eff = keep_count;
      end
   end

   // The row ends at the first score whose column reaches the last column.
   assign row_end   = ({1'b0, counter_ff} + RLW'(1)) >= row_eff;
   assign req_stall = queue_status.full && row_end;
   assign accept    = req_valid && !req_stall;

   // Parallel compares against every kept entry find the insertion rank.
   always_comb begin
      total_cut   = (total_ff > keep_eff) ? keep_eff : total_ff;
      above_floor = req_score > score_floor;
      position    = '0;
      for (int i = 0; i < MAX_KEEP; i++) begin
         not_below[i] = (KCW'(i) < total_cut) && (score_ff[i] >= req_score);
         position     = position + KCW'(not_below[i]);
      end
      insert    = above_floor && (position < keep_eff);
      total_new = (insert && (total_cut < keep_eff)) ? total_cut + KCW'(1) : total_cut;
   end

   // Sorted insertion: entries at or above the new score stay, the rest move
   // down one rank.
   always_comb begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         score_in[j]  = score_ff[j];
         column_in[j] = column_ff[j];
         if (accept && insert && !not_below[j]) begin
            if (j == 0) begin
               score_in[j]  = req_score;
               column_in[j] = counter_ff;
            end else if (not_below[(j > 0) ? j - 1 : 0]) begin
               score_in[j]  = req_score;
               column_in[j] = counter_ff;
            end else begin
               score_in[j]  = score_ff[(j > 0) ? j - 1 : 0];
               column_in[j] = column_ff[(j > 0) ? j - 1 : 0];
            end
         end
      end
   end

   // Column counter and list fill, both restart after a row's last score.
   always_comb begin
      counter_in = counter_ff;
      total_in   = total_ff;
      if (accept) begin
         if (row_end) begin
            counter_in = '0;
            total_in   = '0;
         end else begin
            counter_in = counter_ff + COL_W'(1);
            total_in   = total_new;
         end
      end
   end

   // Snapshot of the finished row for the back part.
   always_comb begin
      push = accept && row_end;
      for (int j = 0; j < MAX_KEEP; j++) begin
         push_data[j*COL_W +: COL_W] = column_in[j];
      end
      push_data[MAX_KEEP*COL_W +: KCW]       = total_new;
      push_data[MAX_KEEP*COL_W + KCW +: KCW] = keep_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         total_ff   <= '0;
      end else begin
         counter_ff <= counter_in;
         total_ff   <= total_in;
      end
   end

   // Kept scores and columns hold payload only.
   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         score_ff[j]  <= score_in[j];
         column_ff[j] <= column_in[j];
      end
   end

endmodule

`default_nettype wire

[hdl/tks_back.sv]
// ----------------------------------------------------------------------------
// Top-k select back part
// Walks the ranks of a finished row and drives the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_back #(
   parameter int MAX_KEEP = 8,
   parameter int MAX_ROW  = 4096,
   localparam int COL_W   = $clog2(MAX_ROW),
   localparam int KCW     = $clog2(MAX_KEEP) + 1,
   localparam int KIW     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1,
   localparam int DATA_W  = MAX_KEEP * COL_W + 2 * KCW
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [DATA_W-1:0]         head_data,
   input  wire tks_pkg::queue_status_type queue_status,
   output      logic                      pop,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [COL_W-1:0]          rsp_column_index,
   output      logic                      rsp_slot_valid,
   output      logic                      rsp_rank_last
);

   logic [KIW-1:0]   rank_ff;
   logic [KIW-1:0]   rank_in;
   logic             valid_ff;
   logic             valid_in;
   logic [COL_W-1:0] column_ff;
   logic [COL_W-1:0] column_in;
   logic             slot_ff;
   logic             slot_in;
   logic             last_ff;
   logic             last_in;

   logic [COL_W-1:0] head_column [MAX_KEEP];
   logic [KCW-1:0]   head_total;
   logic [KCW-1:0]   head_keep;
   logic             load;
   logic             rank_valid;
   logic             rank_final;

   // Unpack the row at the head of the queue.
   always_comb begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         head_column[j] = head_data[j*COL_W +: COL_W];
      end
      head_total = head_data[MAX_KEEP*COL_W +: KCW];
      head_keep  = head_data[MAX_KEEP*COL_W + KCW +: KCW];
   end

   // A new rank enters the output register when it is empty or being taken.
   assign load       = !queue_status.empty && (!valid_ff || !rsp_stall);
   assign rank_valid = KCW'(rank_ff) < head_total;
   assign rank_final = (KCW'(rank_ff) + KCW'(1)) == head_keep;
   assign pop        = load && rank_final;

   always_comb begin
      rank_in   = rank_ff;
      valid_in  = valid_ff;
      column_in = column_ff;
      slot_in   = slot_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         column_in = rank_valid ? head_column[rank_ff] : '0;
         slot_in   = rank_valid;
         last_in   = rank_final;
         rank_in   = rank_final ? '0 : rank_ff + KIW'(1);
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         rank_ff  <= rank_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      column_ff <= column_in;
      slot_ff   <= slot_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_column_index = column_ff;
   assign rsp_slot_valid   = slot_ff;
   assign rsp_rank_last    = last_ff;

endmodule

`default_nettype wire

[hdl/thresholded_top_k_select.sv]
// Thresholded top-k select takes one score per cycle when no stall is shown
// and keeps, per row, the keep_count highest scores above score_floor in a
// sorted list that a bank of parallel compares updates for each new score.
// At a row's last score the list is copied into a two-entry row queue, and
// the back part then emits keep_count results from its output register, one
// per cycle while rsp_stall is low. The front part takes new scores while
// the back part is still emitting earlier rows; the front stalls only on a
// row's last score while both queue entries are taken. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
// Thresholded top-k select
// Top level: configuration registers, front part, row queue and back part.
// ----------------------------------------------------------------------------
`default_nettype none

module thresholded_top_k_select #(
   parameter int MAX_KEEP   = 8,
   parameter int MAX_ROW    = 4096,
   parameter int SCORE_BITS = 16,
   localparam int COL_W     = $clog2(MAX_ROW),
   localparam int RLW       = COL_W + 1,
   localparam int KCW       = $clog2(MAX_KEEP) + 1,
   localparam int CSR_W     = (SCORE_BITS > RLW) ? SCORE_BITS : RLW,
   localparam int DATA_W    = MAX_KEEP * COL_W + 2 * KCW
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [tks_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]                    csr_wdata,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [SCORE_BITS-1:0]        req_score,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [COL_W-1:0]                    rsp_column_index,
   output      logic                                rsp_slot_valid,
   output      logic                                rsp_rank_last
);

   logic [RLW-1:0]               row_length_ff;
   logic [RLW-1:0]               row_length_in;
   logic [KCW-1:0]               keep_count_ff;
   logic [KCW-1:0]               keep_count_in;
   logic signed [SCORE_BITS-1:0] score_floor_ff;
   logic signed [SCORE_BITS-1:0] score_floor_in;

   logic                         push;
   logic [DATA_W-1:0]            push_data;
   logic                         pop;
   logic [DATA_W-1:0]            head_data;
   tks_pkg::queue_status_type    queue_status;

   // Configuration register writes.
   always_comb begin
      row_length_in  = row_length_ff;
      keep_count_in  = keep_count_ff;
      score_floor_in = score_floor_ff;
      if (csr_we) begin
         case (csr_index)
            tks_pkg::CSR_ROW_LENGTH: begin
               row_length_in = csr_wdata[RLW-1:0];
            end
            tks_pkg::CSR_KEEP_COUNT: begin
               keep_count_in = csr_wdata[KCW-1:0];
            end
            tks_pkg::CSR_SCORE_FLOOR: begin
               score_floor_in = csr_wdata[SCORE_BITS-1:0];
            end
            default: begin
               row_length_in = row_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= RLW'(MAX_ROW);
         keep_count_ff  <= KCW'(MAX_KEEP);
         score_floor_ff <= '0;
      end else begin
         row_length_ff  <= row_length_in;
         keep_count_ff  <= keep_count_in;
         score_floor_ff <= score_floor_in;
      end
   end

   // Front part: column count, floor test and sorted insertion.
   tks_front #(
      .MAX_KEEP   (MAX_KEEP),
      .MAX_ROW    (MAX_ROW),
      .SCORE_BITS (SCORE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_score    (req_score),
      .row_length   (row_length_ff),
      .keep_count   (keep_count_ff),
      .score_floor  (score_floor_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   // Finished rows wait here until the back part has emitted earlier ones.
   tks_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   // Back part: one rank per cycle, while rsp_stall is low, into the result register.
   tks_back #(
      .MAX_KEEP (MAX_KEEP),
      .MAX_ROW  (MAX_ROW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_data        (head_data),
      .queue_status     (queue_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_index (rsp_column_index),
      .rsp_slot_valid   (rsp_slot_valid),
      .rsp_rank_last    (rsp_rank_last)
   );

endmodule

`default_nettype wire

[hdl/tks_checker.sv]
// ----------------------------------------------------------------------------
// Top-k select checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tks_checker #(
   parameter int COL_W = 12
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [COL_W-1:0] rsp_column_index,
   input wire logic             rsp_slot_valid,
   input wire logic             rsp_rank_last
);

   logic empty_seen_ff;
   logic empty_seen_in;
   logic rsp_accept;

   assign rsp_accept = rsp_valid && !rsp_stall;

   // Remember an empty rank within the current row.
   always_comb begin
      empty_seen_in = empty_seen_ff;
      if (rsp_accept) begin
         empty_seen_in = !rsp_rank_last && (empty_seen_ff || !rsp_slot_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_seen_ff <= 1'b0;
      end else begin
         empty_seen_ff <= empty_seen_in;
      end
   end

   // A held result keeps its payload.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_column_index) && $stable(rsp_slot_valid) && $stable(rsp_rank_last), "result changed while stalled")

   // An empty rank reports column zero.
   `ASSERT_CLK_RST(a_empty_col, clock, reset, rsp_valid && !rsp_slot_valid |-> rsp_column_index == '0, "empty rank with nonzero column")

   // Once a rank is empty, all lower ranks of the row are empty too.
   `ASSERT_CLK_RST(a_empty_tail, clock, reset, rsp_valid && empty_seen_ff |-> !rsp_slot_valid, "kept rank after an empty rank")

   // No result is offered right after reset.
   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind thresholded_top_k_select tks_checker #(
   .COL_W ($clog2(MAX_ROW))
) u_tks_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_column_index (rsp_column_index),
   .rsp_slot_valid   (rsp_slot_valid),
   .rsp_rank_last    (rsp_rank_last)
);

`default_nettype wire
